/* hw/rtl/scc_pkg.sv */
// scc_pkg: types, codes and constants for the system control coprocessor
// used by scc_regfile and system_control_coprocessor; no dependencies
package scc_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_CMD   = 2'd2,
        MODE_EXC   = 2'd3
    } mode_t;

    localparam logic [4:0] REG_RSVD_0       = 5'd0;
    localparam logic [4:0] REG_RSVD_1       = 5'd1;
    localparam logic [4:0] REG_RSVD_2       = 5'd2;
    localparam logic [4:0] REG_EXEC_BP      = 5'd3;
    localparam logic [4:0] REG_RSVD_4       = 5'd4;
    localparam logic [4:0] REG_DATA_BP      = 5'd5;
    localparam logic [4:0] REG_BP_CTRL      = 5'd7;
    localparam logic [4:0] REG_BAD_ADDR     = 5'd8;
    localparam logic [4:0] REG_DATA_BP_MASK = 5'd9;
    localparam logic [4:0] REG_RSVD_10      = 5'd10;
    localparam logic [4:0] REG_EXEC_BP_MASK = 5'd11;
    localparam logic [4:0] REG_STATUS       = 5'd12;
    localparam logic [4:0] REG_CAUSE        = 5'd13;
    localparam logic [4:0] REG_EPC          = 5'd14;

    localparam logic [DataWidth-1:0] CMD_RFE = 32'h0000_0010;

    localparam logic [4:0] EXC_INTERRUPT     = 5'd0;
    localparam logic [4:0] EXC_RESERVED_INSN = 5'd10;

    localparam logic [DataWidth-1:0] CAUSE_WRITE_MASK = 32'h0000_0300;

    typedef struct packed {
        mode_t                mode;
        logic [4:0]           reg_index;
        logic [DataWidth-1:0] data_in;
        logic [4:0]           exc_code;
        logic [1:0]           exc_cop_number;
        logic [DataWidth-1:0] fault_address;
        logic                 in_delay_slot;
        logic [DataWidth-1:0] current_pc;
    } item_t;

    typedef struct packed {
        logic [DataWidth-1:0] read_data;
        logic                 exception_raised;
    } result_t;

endpackage

/* hw/rtl/system_control_coprocessor.sv */
// system_control_coprocessor: top level of the coprocessor 0 block
// depends on scc_pkg and scc_regfile
//
// usage:
//   one word on the item channel is a register read, a register write, a
//   coprocessor command or an exception entry; each gives one result word
//   (read data and an exception flag) on the result channel
//   a word is taken when item_valid is high and item_stall is low, and
//   handed over when result_valid is high and result_stall is low
//   the item goes into an input register; the edge at which it advances
//   updates the coprocessor registers, loads the result register and
//   raises result_valid
//   throughput: one item per cycle, set by the single decode/update path
//   while the result register is stalled, a held item waits in the input
//   register and item_stall rises only once both registers are full
//   reset clears all coprocessor registers to zero and empties both stages
module system_control_coprocessor
    import scc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t calc;
    logic    advance;
    logic    take;

    scc_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_reg),
        .result (calc)
    );

    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || !result_stall);
        item_stall     = in_valid_reg && !advance;
        take           = item_valid && !item_stall;
        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            out_reg <= calc;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    ap_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg && out_valid_reg)
        else $error("item stalled with a free stage");

    ap_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    ap_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg && out_valid_reg && !result_stall |=> !out_valid_reg)
        else $error("result repeated");

endmodule

/* hw/rtl/scc_regfile.sv */
// scc_regfile: coprocessor register state and the per-item decode and update
// depends on scc_pkg; state changes on the clock edge at which commit is high
module scc_regfile
    import scc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    commit,
    input  item_t   item,
    output result_t result
);

    logic [DataWidth-1:0] exec_bp_reg, exec_bp_next;
    logic [DataWidth-1:0] data_bp_reg, data_bp_next;
    logic [DataWidth-1:0] bp_ctrl_reg, bp_ctrl_next;
    logic [DataWidth-1:0] bad_addr_reg, bad_addr_next;
    logic [DataWidth-1:0] data_bp_mask_reg, data_bp_mask_next;
    logic [DataWidth-1:0] exec_bp_mask_reg, exec_bp_mask_next;
    logic [DataWidth-1:0] status_reg, status_next;
    logic [DataWidth-1:0] cause_reg, cause_next;
    logic [DataWidth-1:0] epc_reg, epc_next;

    logic                 reserved;
    logic                 raise_int;
    logic                 take_exc;
    logic [4:0]           code;
    logic [1:0]           cop;
    logic [DataWidth-1:0] badv;
    logic [DataWidth-1:0] rd;
    logic                 is_write;

    always_comb
    begin
        reserved  = item.reg_index inside {REG_RSVD_0, REG_RSVD_1, REG_RSVD_2,
                                           REG_RSVD_4, REG_RSVD_10};
        raise_int = ((item.mode == MODE_READ || item.mode == MODE_WRITE) && reserved)
                    || (item.mode == MODE_CMD && item.data_in != CMD_RFE);
        take_exc  = raise_int || item.mode == MODE_EXC;
        code      = raise_int ? EXC_RESERVED_INSN : item.exc_code;
        cop       = raise_int ? 2'd0 : item.exc_cop_number;
        badv      = raise_int ? '0 : item.fault_address;
        is_write  = item.mode == MODE_WRITE && !reserved;
    end

    // read path
    always_comb
    begin
        rd = '0;
        if (item.mode == MODE_READ && !reserved)
        begin
            if (item.reg_index[4])
            begin
                rd = cause_reg ^ ~epc_reg ^ status_reg;
            end
            else
            begin
                case (item.reg_index)
                    REG_EXEC_BP:      rd = exec_bp_reg;
                    REG_DATA_BP:      rd = data_bp_reg;
                    REG_BP_CTRL:      rd = bp_ctrl_reg;
                    REG_BAD_ADDR:     rd = bad_addr_reg;
                    REG_DATA_BP_MASK: rd = data_bp_mask_reg;
                    REG_EXEC_BP_MASK: rd = exec_bp_mask_reg;
                    REG_STATUS:       rd = status_reg;
                    REG_CAUSE:        rd = cause_reg;
                    REG_EPC:          rd = epc_reg;
                    default:          rd = '0;
                endcase
            end
        end
    end

    assign result.read_data        = rd;
    assign result.exception_raised = take_exc;

    // update path
    always_comb
    begin
        exec_bp_next      = exec_bp_reg;
        data_bp_next      = data_bp_reg;
        bp_ctrl_next      = bp_ctrl_reg;
        bad_addr_next     = bad_addr_reg;
        data_bp_mask_next = data_bp_mask_reg;
        exec_bp_mask_next = exec_bp_mask_reg;
        status_next       = status_reg;
        cause_next        = cause_reg;
        epc_next          = epc_reg;
        if (is_write)
        begin
            case (item.reg_index)
                REG_EXEC_BP:      exec_bp_next      = item.data_in;
                REG_DATA_BP:      data_bp_next      = item.data_in;
                REG_BP_CTRL:      bp_ctrl_next      = item.data_in;
                REG_DATA_BP_MASK: data_bp_mask_next = item.data_in;
                REG_EXEC_BP_MASK: exec_bp_mask_next = item.data_in;
                REG_STATUS:       status_next       = item.data_in;
                REG_CAUSE:        cause_next = (cause_reg & ~CAUSE_WRITE_MASK)
                                             | (item.data_in & CAUSE_WRITE_MASK);
                default:          ;
            endcase
        end
        if (item.mode == MODE_CMD && !raise_int)
        begin
            status_next = {status_reg[DataWidth-1:4], status_reg[5:2]};
        end
        if (take_exc)
        begin
            cause_next    = {item.in_delay_slot, cause_reg[30], cop, cause_reg[27:7],
                             code, cause_reg[1:0]};
            bad_addr_next = badv;
            // delay-slot faults other than interrupts return to the branch
            if (item.in_delay_slot && code != EXC_INTERRUPT)
            begin
                epc_next = item.current_pc;
            end
            else
            begin
                epc_next = item.current_pc + DataWidth'(4);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_bp_reg      <= '0;
            data_bp_reg      <= '0;
            bp_ctrl_reg      <= '0;
            bad_addr_reg     <= '0;
            data_bp_mask_reg <= '0;
            exec_bp_mask_reg <= '0;
            status_reg       <= '0;
            cause_reg        <= '0;
            epc_reg          <= '0;
        end
        else if (commit)
        begin
            exec_bp_reg      <= exec_bp_next;
            data_bp_reg      <= data_bp_next;
            bp_ctrl_reg      <= bp_ctrl_next;
            bad_addr_reg     <= bad_addr_next;
            data_bp_mask_reg <= data_bp_mask_next;
            exec_bp_mask_reg <= exec_bp_mask_next;
            status_reg       <= status_next;
            cause_reg        <= cause_next;
            epc_reg          <= epc_next;
        end
    end

    ap_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.mode == MODE_EXC |=> cause_reg[6:2] == $past(item.exc_code))
        else $error("exception code not recorded in cause");

    ap_rfe_pop: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.mode == MODE_CMD && item.data_in == CMD_RFE
        |=> status_reg[3:0] == $past(status_reg[5:2]))
        else $error("return from exception did not pop status stack");

    ap_internal_exc: assert property (@(posedge clk) disable iff (!rst_n)
        commit && raise_int |=> cause_reg[6:2] == EXC_RESERVED_INSN && bad_addr_reg == '0)
        else $error("internal exception recorded wrongly");

    ap_no_exc_keep: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !take_exc |=> $stable(epc_reg) && $stable(bad_addr_reg))
        else $error("return address changed without an exception");

endmodule

/* tb/sv/system_control_coprocessor_tb.sv */
// system_control_coprocessor_tb: self-checking testbench for the coprocessor 0 block
// drives item words, predicts each result word and checks it against the result channel
// depends on scc_pkg and system_control_coprocessor
module system_control_coprocessor_tb;
    import scc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] REG_ZERO_6       = 5'd6;
    localparam logic [4:0] REG_ZERO_15      = 5'd15;
    localparam logic [4:0] REG_MIRROR_FIRST = 5'd16;
    localparam logic [4:0] REG_MIRROR_LAST  = 5'd31;
    localparam logic [4:0] EXC_CODE_MAX     = 5'd31;
    localparam logic [1:0] COP_ZERO         = 2'd0;
    localparam logic [1:0] COP_MAX          = 2'd3;
    localparam int         RANDOM_PER_PHASE = 270;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    item_t   pending_items[$];
    result_t expected_results[$];
    result_t want_res;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    logic    hold_on = 1'b0;
    int      errors = 0;

    // predicted coprocessor registers
    logic [31:0] bp_exec = '0;
    logic [31:0] bp_data = '0;
    logic [31:0] bp_ctrl = '0;
    logic [31:0] badvaddr = '0;
    logic [31:0] bp_data_mask = '0;
    logic [31:0] bp_exec_mask = '0;
    logic [31:0] sr = '0;
    logic [31:0] cause = '0;
    logic [31:0] epc = '0;

    system_control_coprocessor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    function automatic void take_exception(logic [4:0] code, logic [1:0] cop,
                                           logic [31:0] badv, logic bd, logic [31:0] pc);
        cause[6:2]   = code;
        cause[29:28] = cop;
        cause[31]    = bd;
        badvaddr     = badv;
        epc          = pc + 32'd4;
        if (code != EXC_INTERRUPT && bd)
            epc = epc - 32'd4;
    endfunction

    function automatic result_t cop0_step(item_t it);
        result_t res;
        logic    rsvd;
        logic    fault;
        res   = '0;
        fault = 1'b0;
        rsvd  = it.reg_index == REG_RSVD_0 || it.reg_index == REG_RSVD_1 ||
                it.reg_index == REG_RSVD_2 || it.reg_index == REG_RSVD_4 ||
                it.reg_index == REG_RSVD_10;
        case (it.mode)
            MODE_READ:
            begin
                if (rsvd)
                    fault = 1'b1;
                else if (it.reg_index >= REG_MIRROR_FIRST)
                    res.read_data = cause ^ ~epc ^ sr;
                else
                begin
                    case (it.reg_index)
                        REG_EXEC_BP:      res.read_data = bp_exec;
                        REG_DATA_BP:      res.read_data = bp_data;
                        REG_BP_CTRL:      res.read_data = bp_ctrl;
                        REG_BAD_ADDR:     res.read_data = badvaddr;
                        REG_DATA_BP_MASK: res.read_data = bp_data_mask;
                        REG_EXEC_BP_MASK: res.read_data = bp_exec_mask;
                        REG_STATUS:       res.read_data = sr;
                        REG_CAUSE:        res.read_data = cause;
                        REG_EPC:          res.read_data = epc;
                        default:          res.read_data = '0;
                    endcase
                end
            end
            MODE_WRITE:
            begin
                if (rsvd)
                    fault = 1'b1;
                else
                begin
                    case (it.reg_index)
                        REG_EXEC_BP:      bp_exec = it.data_in;
                        REG_DATA_BP:      bp_data = it.data_in;
                        REG_BP_CTRL:      bp_ctrl = it.data_in;
                        REG_DATA_BP_MASK: bp_data_mask = it.data_in;
                        REG_EXEC_BP_MASK: bp_exec_mask = it.data_in;
                        REG_STATUS:       sr = it.data_in;
                        REG_CAUSE:
                            cause = (cause & ~CAUSE_WRITE_MASK) | (it.data_in & CAUSE_WRITE_MASK);
                        default: ;
                    endcase
                end
            end
            MODE_CMD:
            begin
                if (it.data_in == CMD_RFE)
                    sr[3:0] = sr[5:2];
                else
                    fault = 1'b1;
            end
            default:
            begin
                take_exception(it.exc_code, it.exc_cop_number, it.fault_address,
                               it.in_delay_slot, it.current_pc);
                res.exception_raised = 1'b1;
            end
        endcase
        if (fault)
        begin
            take_exception(EXC_RESERVED_INSN, COP_ZERO, '0, it.in_delay_slot, it.current_pc);
            res.read_data        = '0;
            res.exception_raised = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    sel;
        it.exc_code       = 5'($urandom_range(31));
        it.exc_cop_number = 2'($urandom_range(3));
        it.fault_address  = rand_word();
        it.in_delay_slot  = 1'($urandom_range(1));
        it.current_pc     = rand_word();
        it.data_in        = rand_word();
        sel = $urandom_range(99);
        if (sel < 35)
            it.mode = MODE_READ;
        else if (sel < 65)
            it.mode = MODE_WRITE;
        else if (sel < 80)
            it.mode = MODE_CMD;
        else
            it.mode = MODE_EXC;
        case ($urandom_range(3))
            0:       it.reg_index = 5'($urandom_range(31));
            1:       it.reg_index = 5'($urandom_range(15));
            default:
            begin
                case ($urandom_range(3))
                    0:       it.reg_index = REG_STATUS;
                    1:       it.reg_index = REG_CAUSE;
                    2:       it.reg_index = REG_EPC;
                    default: it.reg_index = REG_BAD_ADDR;
                endcase
            end
        endcase
        if (it.mode == MODE_CMD && $urandom_range(1) == 0)
            it.data_in = CMD_RFE;
        return it;
    endfunction

    function automatic item_t mk(mode_t m, logic [4:0] r, logic [31:0] d);
        item_t it;
        it           = rand_item();
        it.mode      = m;
        it.reg_index = r;
        it.data_in   = d;
        return it;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(cop0_step(item));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, result);
                    errors++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (result.read_data !== want_res.read_data)
                    begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, want_res.read_data, result.read_data);
                        errors++;
                    end
                    if (result.exception_raised !== want_res.exception_raised)
                    begin
                        $display("%0t: exception_raised mismatch, expected %b, actual %b",
                                 $time, want_res.exception_raised, result.exception_raised);
                        errors++;
                    end
                end
            end
            result_stall <= hold_on || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_random(int n);
        repeat (n)
            pending_items.push_back(rand_item());
    endtask

    initial
    begin
        item_t it;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words
        pending_items.push_back(mk(MODE_READ, REG_STATUS, '0));
        pending_items.push_back(mk(MODE_WRITE, REG_STATUS, '1));
        pending_items.push_back(mk(MODE_WRITE, REG_CAUSE, '1));
        pending_items.push_back(mk(MODE_READ, REG_CAUSE, '0));
        pending_items.push_back(mk(MODE_WRITE, REG_EXEC_BP, '1));
        pending_items.push_back(mk(MODE_WRITE, REG_DATA_BP, 32'hA5A5_5A5A));
        pending_items.push_back(mk(MODE_WRITE, REG_BP_CTRL, 32'h8000_0001));
        pending_items.push_back(mk(MODE_WRITE, REG_DATA_BP_MASK, '1));
        pending_items.push_back(mk(MODE_WRITE, REG_EXEC_BP_MASK, 32'h1234_5678));
        pending_items.push_back(mk(MODE_WRITE, REG_ZERO_6, '1));
        pending_items.push_back(mk(MODE_WRITE, REG_MIRROR_LAST, '1));
        pending_items.push_back(mk(MODE_READ, REG_ZERO_15, '0));
        pending_items.push_back(mk(MODE_READ, REG_MIRROR_FIRST, '0));
        pending_items.push_back(mk(MODE_WRITE, REG_STATUS, 32'h0000_003C));
        pending_items.push_back(mk(MODE_CMD, REG_RSVD_0, CMD_RFE));
        pending_items.push_back(mk(MODE_CMD, REG_RSVD_0, '1));
        pending_items.push_back(mk(MODE_CMD, REG_RSVD_0, '0));
        it = mk(MODE_EXC, REG_RSVD_0, '0);
        it.exc_code = EXC_INTERRUPT; it.exc_cop_number = COP_MAX;
        it.fault_address = '1; it.in_delay_slot = 1'b1; it.current_pc = 32'hFFFF_FFFC;
        pending_items.push_back(it);
        pending_items.push_back(mk(MODE_READ, REG_EPC, '0));
        it.exc_code = EXC_CODE_MAX; it.current_pc = '0;
        pending_items.push_back(it);
        pending_items.push_back(mk(MODE_READ, REG_BAD_ADDR, '0));
        pending_items.push_back(mk(MODE_READ, REG_MIRROR_LAST, '0));
        it = mk(MODE_READ, REG_RSVD_4, '0);
        it.in_delay_slot = 1'b1;
        pending_items.push_back(it);
        pending_items.push_back(mk(MODE_WRITE, REG_RSVD_10, '1));
        pending_items.push_back(mk(MODE_READ, REG_CAUSE, '0));
        drain();

        push_random(RANDOM_PER_PHASE);
        drain();

        send_idle_pct <= 58;
        push_random(RANDOM_PER_PHASE);
        drain();

        send_idle_pct <= 0;
        stall_pct     <= 58;
        push_random(RANDOM_PER_PHASE);
        drain();

        send_idle_pct <= 16;
        stall_pct     <= 16;
        push_random(RANDOM_PER_PHASE);
        drain();

        // long receiver hold-off while the sender keeps offering words
        send_idle_pct <= 0;
        stall_pct     <= 16;
        push_random(RANDOM_PER_PHASE);
        fork
            begin
                hold_on <= 1'b1;
                repeat (60) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("system_control_coprocessor verification clean");
        else
            $display("system_control_coprocessor verification failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("system_control_coprocessor verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/scc_pkg.sv
hw/rtl/scc_regfile.sv
hw/rtl/system_control_coprocessor.sv
tb/sv/system_control_coprocessor_tb.sv
